// ===== design/tss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants for the triangle scanline span block
// Word layouts between pipeline stages, register indexes, image limits.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int COORD_W            = 8;
    localparam int PROD_W             = 2 * COORD_W;
    localparam int IMAGE_SIZE         = 256;
    localparam int IMG_W              = 13;
    localparam logic [IMG_W-1:0] IMG_SIZE_C = IMG_W'(IMAGE_SIZE);
    localparam logic [IMG_W-1:0] IMG_LAST   = IMG_W'(IMAGE_SIZE - 1);

    // quotient bits resolved per divider stage
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int NUM_DIV_STAGES     = COORD_W / DIV_BITS_PER_STAGE;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_V1_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_V1_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_V2_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_V2_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_V3_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_V3_Y = 3'd5;

    // register reset values
    localparam logic [COORD_W-1:0] RST_V1_X = 8'd10;
    localparam logic [COORD_W-1:0] RST_V1_Y = 8'd20;
    localparam logic [COORD_W-1:0] RST_V2_X = 8'd5;
    localparam logic [COORD_W-1:0] RST_V2_Y = 8'd30;
    localparam logic [COORD_W-1:0] RST_V3_X = 8'd50;
    localparam logic [COORD_W-1:0] RST_V3_Y = 8'd50;

    typedef struct packed {
        logic [COORD_W-1:0] v1_x;
        logic [COORD_W-1:0] v1_y;
        logic [COORD_W-1:0] v2_x;
        logic [COORD_W-1:0] v2_y;
        logic [COORD_W-1:0] v3_x;
        logic [COORD_W-1:0] v3_y;
    } vertex_cfg_t;

    // edge from column a to column b, offset k of height d (d >= 1, k <= d)
    typedef struct packed {
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        logic [COORD_W-1:0] k;
        logic [COORD_W-1:0] d;
    } edge_setup_t;

    typedef struct packed {
        logic        covered;
        edge_setup_t long_e;
        edge_setup_t short_e;
    } setup_word_t;

    typedef struct packed {
        logic [PROD_W-1:0]  pa;
        logic [PROD_W-1:0]  pb;
        logic [COORD_W-1:0] d;
    } edge_prod_t;

    typedef struct packed {
        logic       covered;
        edge_prod_t long_e;
        edge_prod_t short_e;
    } prod_word_t;

    typedef struct packed {
        logic [PROD_W-1:0]  rem;
        logic [COORD_W-1:0] d;
        logic [COORD_W-1:0] q;
    } edge_div_t;

    typedef struct packed {
        logic      covered;
        edge_div_t long_e;
        edge_div_t short_e;
    } div_word_t;

endpackage

// ===== design/triangle_scanline_span.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_scanline_span: filled-triangle span for one scanline row
// Returns the covered column range of a row for a triangle whose vertices
// sit in configuration registers (ordered top, middle, bottom by row).
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  tdata: row
//  m_       out        m_tvalid/m_tready  tdata: span_start, span_end; tuser: covered
//  cfg_     in         cfg_valid/ready    cfg_index, cfg_data (always ready)
//
//  One word per cycle sustained while m_tready is high; accept to m_tvalid passes
//  3 set-up stages, 4 divider stages at 2 quotient bits each, and the output reg.
//  Each stage holds its own valid bit; ready chains back stage by stage, so
//  empty slots are filled while the output word waits.
//  Reset (aresetn, synchronous) clears all valid bits and loads the default
//  triangle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module triangle_scanline_span
    import tss_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // input row words
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [COORD_W-1:0]        s_tdata,   // [7:0] row
    // span words
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [2*COORD_W-1:0]      m_tdata,   // [7:0] span_start, [15:8] span_end
    output logic                      m_tuser,   // [0] covered
    // vertex configuration
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_data
);

    vertex_cfg_t vtx;

    // divider chain: index 0 is the set-up output, last is the final quotient
    div_word_t dv_word  [NUM_DIV_STAGES+1];
    logic      dv_valid [NUM_DIV_STAGES+1];
    logic      dv_ready [NUM_DIV_STAGES+1];

    logic [COORD_W-1:0]   lo_col, hi_col, lo_clip, hi_clip;
    logic [2*COORD_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tvalid_reg;

    tss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vtx       (vtx)
    );

    // row test, edge pick, products and numerators
    tss_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .vtx       (vtx),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_row    (s_tdata),
        .out_valid (dv_valid[0]),
        .out_ready (dv_ready[0]),
        .out_word  (dv_word[0])
    );

    // restoring divider, most significant quotient bits first
    for (genvar i = 0; i < NUM_DIV_STAGES; i++) begin : g_div
        tss_div_stage #(
            .HI_BIT (COORD_W - 1 - i * DIV_BITS_PER_STAGE)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[i]),
            .in_ready  (dv_ready[i]),
            .in_word   (dv_word[i]),
            .out_valid (dv_valid[i+1]),
            .out_ready (dv_ready[i+1]),
            .out_word  (dv_word[i+1])
        );
    end

    // output stage: order the long- and short-edge columns, clip to the image, zero when
    // the row misses the triangle
    assign dv_ready[NUM_DIV_STAGES] = !m_tvalid_reg || m_tready;

    always_comb begin
        if (dv_word[NUM_DIV_STAGES].short_e.q > dv_word[NUM_DIV_STAGES].long_e.q) begin
            lo_col = dv_word[NUM_DIV_STAGES].long_e.q;
            hi_col = dv_word[NUM_DIV_STAGES].short_e.q;
        end else begin
            lo_col = dv_word[NUM_DIV_STAGES].short_e.q;
            hi_col = dv_word[NUM_DIV_STAGES].long_e.q;
        end
        lo_clip = ({5'b0, lo_col} > IMG_LAST) ? IMG_LAST[COORD_W-1:0] : lo_col;
        hi_clip = ({5'b0, hi_col} > IMG_LAST) ? IMG_LAST[COORD_W-1:0] : hi_col;
        m_tdata_next = dv_word[NUM_DIV_STAGES].covered ? {hi_clip, lo_clip} : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (dv_ready[NUM_DIV_STAGES]) begin
            m_tvalid_reg <= dv_valid[NUM_DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (dv_ready[NUM_DIV_STAGES] && dv_valid[NUM_DIV_STAGES]) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= dv_word[NUM_DIV_STAGES].covered;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a row outside the triangle carries an empty span
    a_uncovered_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("uncovered row with nonzero span");

    // span ends are ordered
    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[COORD_W-1:0] <= m_tdata[2*COORD_W-1:COORD_W])
        else $error("span start beyond span end");

    // the divider has fully reduced both numerators
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_valid[NUM_DIV_STAGES] |->
            dv_word[NUM_DIV_STAGES].long_e.rem < PROD_W'(dv_word[NUM_DIV_STAGES].long_e.d)
            && dv_word[NUM_DIV_STAGES].short_e.rem
               < PROD_W'(dv_word[NUM_DIV_STAGES].short_e.d))
        else $error("divider remainder not below divisor");

    // span end stays inside the image
    a_span_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> {5'b0, m_tdata[2*COORD_W-1:COORD_W]} <= IMG_LAST)
        else $error("span end outside image");

endmodule

// ===== design/tss_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_cfg_regs: vertex configuration registers
// Six 8-bit registers written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tss_cfg_regs
    import tss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    output vertex_cfg_t          vtx
);

    vertex_cfg_t vtx_reg;
    vertex_cfg_t vtx_next;

    assign cfg_ready = 1'b1;
    assign vtx       = vtx_reg;

    always_comb begin
        vtx_next = vtx_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_V1_X: vtx_next.v1_x = cfg_data;
                REG_V1_Y: vtx_next.v1_y = cfg_data;
                REG_V2_X: vtx_next.v2_x = cfg_data;
                REG_V2_Y: vtx_next.v2_y = cfg_data;
                REG_V3_X: vtx_next.v3_x = cfg_data;
                REG_V3_Y: vtx_next.v3_y = cfg_data;
                default:  vtx_next = vtx_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vtx_reg.v1_x <= RST_V1_X;
            vtx_reg.v1_y <= RST_V1_Y;
            vtx_reg.v2_x <= RST_V2_X;
            vtx_reg.v2_y <= RST_V2_Y;
            vtx_reg.v3_x <= RST_V3_X;
            vtx_reg.v3_y <= RST_V3_Y;
        end else begin
            vtx_reg <= vtx_next;
        end
    end

endmodule

// ===== design/tss_setup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_setup: edge set-up, products and numerators
// Three stages: row test and edge pick, a*(d-k) and b*k, numerator sum.
// ----------------------------------------------------------------------------
module tss_setup
    import tss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  vertex_cfg_t        vtx,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] in_row,
    output logic               out_valid,
    input  logic               out_ready,
    output div_word_t          out_word
);

    function automatic edge_setup_t make_edge(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b,
        input logic [COORD_W-1:0] k,
        input logic [COORD_W-1:0] h
    );
        edge_setup_t e;
        e.a = a;
        e.b = b;
        e.d = (h == '0) ? COORD_W'(1) : h;
        e.k = (k > e.d) ? e.d : k;
        return e;
    endfunction

    function automatic edge_prod_t make_prod(input edge_setup_t e);
        edge_prod_t p;
        p.pa = PROD_W'(e.a) * PROD_W'(e.d - e.k);
        p.pb = PROD_W'(e.b) * PROD_W'(e.k);
        p.d  = e.d;
        return p;
    endfunction

    setup_word_t s1_word_reg, s1_word_next;
    prod_word_t  s2_word_reg, s2_word_next;
    div_word_t   s3_word_reg, s3_word_next;
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        s2_ready, s3_ready;
    logic        upper;

    assign in_ready  = !s1_valid_reg || s2_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign out_valid = s3_valid_reg;
    assign out_word  = s3_word_reg;

    // stage 1: coverage test and edge selection
    always_comb begin
        upper = (in_row <= vtx.v2_y);
        s1_word_next.covered = (in_row >= vtx.v1_y) && (in_row <= vtx.v3_y)
                               && ({5'b0, in_row} < IMG_SIZE_C);
        s1_word_next.long_e  = make_edge(vtx.v1_x, vtx.v3_x, in_row - vtx.v1_y,
                                         vtx.v3_y - vtx.v1_y);
        if (upper) begin
            s1_word_next.short_e = make_edge(vtx.v1_x, vtx.v2_x, in_row - vtx.v1_y,
                                             vtx.v2_y - vtx.v1_y);
        end else begin
            s1_word_next.short_e = make_edge(vtx.v2_x, vtx.v3_x, in_row - vtx.v2_y,
                                             vtx.v3_y - vtx.v2_y);
        end
    end

    // stage 2: products
    always_comb begin
        s2_word_next.covered = s1_word_reg.covered;
        s2_word_next.long_e  = make_prod(s1_word_reg.long_e);
        s2_word_next.short_e = make_prod(s1_word_reg.short_e);
    end

    // stage 3: numerators; long edge biased by d-1 to round up
    always_comb begin
        s3_word_next.covered   = s2_word_reg.covered;
        s3_word_next.long_e.d  = s2_word_reg.long_e.d;
        s3_word_next.long_e.q  = '0;
        s3_word_next.long_e.rem = s2_word_reg.long_e.pa + s2_word_reg.long_e.pb
                                  + PROD_W'(s2_word_reg.long_e.d) - PROD_W'(1);
        s3_word_next.short_e.d = s2_word_reg.short_e.d;
        s3_word_next.short_e.q = '0;
        s3_word_next.short_e.rem = s2_word_reg.short_e.pa + s2_word_reg.short_e.pb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (in_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid)     s1_word_reg <= s1_word_next;
        if (s2_ready && s1_valid_reg) s2_word_reg <= s2_word_next;
        if (s3_ready && s2_valid_reg) s3_word_reg <= s3_word_next;
    end

endmodule

// ===== design/tss_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_div_stage: one stage of the restoring divider
// Resolves quotient bits HI_BIT downward for both edges, then registers.
// ----------------------------------------------------------------------------
module tss_div_stage
    import tss_pkg::*;
#(
    parameter int HI_BIT = COORD_W - 1
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_word_t in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output div_word_t out_word
);

    function automatic edge_div_t div_steps(input edge_div_t e);
        edge_div_t          r;
        logic [PROD_W-1:0]  sh;
        int                 bpos;
        r = e;
        for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
            bpos = HI_BIT - j;
            sh   = PROD_W'(r.d) << bpos;
            if (r.rem >= sh) begin
                r.rem = r.rem - sh;
                r.q[3'(bpos)] = 1'b1;
            end
        end
        return r;
    endfunction

    div_word_t word_reg, word_next;
    logic      valid_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb begin
        word_next.covered = in_word.covered;
        word_next.long_e  = div_steps(in_word.long_e);
        word_next.short_e = div_steps(in_word.short_e);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) word_reg <= word_next;
    end

endmodule
